>>> hw/rtl/i2cm_pkg.sv
// i2cm_pkg: shared types and codes of the i2c master bit engine
// request/result payload structs, phase codes, command modes, csr indexes
// no dependencies
package i2cm_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_LIMIT   = 2'd2;

   localparam logic [15:0] HOLD_TICKS_RESET   = 16'd50;
   localparam logic [15:0] SETTLE_TICKS_RESET = 16'd100;
   localparam logic [7:0]  POLL_LIMIT_RESET   = 8'd255;

   localparam logic [7:0] NACK_PATTERN = 8'h80;
   localparam logic [7:0] ACK_PATTERN  = 8'h00;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;
   localparam logic [2:0] MIN_FRAME_LEN = 3'd2;

   typedef enum logic [2:0] {
      MODE_START      = 3'd0,
      MODE_STOP       = 3'd1,
      MODE_WRITE      = 3'd2,
      MODE_CHECK_ACK  = 3'd3,
      MODE_READ       = 3'd4,
      MODE_MASTER_ACK = 3'd5,
      MODE_MASTER_NAK = 3'd6,
      MODE_FRAME      = 3'd7
   } mode_type;

   typedef enum logic [19:0] {
      PH_IDLE = 20'h00001,
      PH_ST_A = 20'h00002,
      PH_ST_B = 20'h00004,
      PH_ST_C = 20'h00008,
      PH_SP_A = 20'h00010,
      PH_SP_B = 20'h00020,
      PH_SP_C = 20'h00040,
      PH_WR_D = 20'h00080,
      PH_WR_H = 20'h00100,
      PH_WR_L = 20'h00200,
      PH_CK_R = 20'h00400,
      PH_CK_S = 20'h00800,
      PH_CK_P = 20'h01000,
      PH_RD_L = 20'h02000,
      PH_RD_H = 20'h04000,
      PH_RD_S = 20'h08000,
      PH_RD_E = 20'h10000,
      PH_MA_D = 20'h20000,
      PH_MA_H = 20'h40000,
      PH_MA_E = 20'h80000
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] mode;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [2:0] frame_len;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_oe;
      logic       busy_res;
      logic       done_res;
      logic       ack_ok;
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic [15:0] hold_ticks;
      logic [15:0] ack_settle_ticks;
      logic [7:0]  poll_limit;
   } cfg_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic oe;
   } pins_type;

endpackage

>>> hw/rtl/i2cm_ifs.sv
// i2cm_ifs: valid/ready channel interfaces for requests and results
// depends on i2cm_pkg for the payload types
interface i2cm_req_if;
   import i2cm_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface i2cm_rsp_if;
   import i2cm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/i2c_master_bit_engine.sv
// i2c_master_bit_engine: top level of the i2c master bit engine
// request register, step engine, result register and csr bank
// depends on i2cm_pkg, i2cm_ifs, i2cm_engine
//
//   channel    | dir | handshake          | carries
//   req_chan   | in  | valid/ready        | one bus tick: command, bytes, sda sample
//   rsp_chan   | out | valid/ready        | pin levels, busy, done, ack, read byte
//   csr_*      | in  | write enable only  | hold, settle and poll settings
//
// one request per cycle sustained while the result side is not stalled; a request
// passes through the request register and then into the result register
// the bus state advances only when a request moves into the result register
// a stalled result holds both registers; the request side keeps accepting
// while a slot is free
// synchronous active-high reset restores default settings and an idle bus
module i2c_master_bit_engine #(
   parameter int FRAME_BYTES = 4,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   i2cm_req_if.sink                           req_chan,
   i2cm_rsp_if.source                         rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import i2cm_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type step_result;
   cfg_type cfg_ff, cfg_in;
   logic    advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

   assign in_valid_in  = req_chan.valid || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   i2cm_engine #(
      .FRAME_BYTES (FRAME_BYTES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HOLD_TICKS:   cfg_in.hold_ticks       = csr_wr_data;
            CSR_SETTLE_TICKS: cfg_in.ack_settle_ticks = csr_wr_data;
            CSR_POLL_LIMIT:   cfg_in.poll_limit       = csr_wr_data[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '{hold_ticks:       HOLD_TICKS_RESET,
                           ack_settle_ticks: SETTLE_TICKS_RESET,
                           poll_limit:       POLL_LIMIT_RESET};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) in_item_ff <= req_chan.payload;
      if (advance) out_item_ff <= step_result;
   end

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("stepped request did not reach the result register");

   a_held_request_stable: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("waiting request was lost or changed");

   a_idle_drives_sda: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_item_ff.busy_res |-> out_item_ff.sda_oe)
      else $error("sda released while idle");

   a_done_is_busy: assert property (@(posedge clock) disable iff (reset)
      advance && step_result.done_res |=> out_item_ff.busy_res)
      else $error("finish reported outside a command");

endmodule

>>> hw/rtl/i2cm_engine.sv
// i2cm_engine: bus state of the i2c master and its per-tick step logic
// one step per request, result computed combinationally from state and request
// depends on i2cm_pkg
module i2cm_engine #(
   parameter int FRAME_BYTES = 4,
   parameter int COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  i2cm_pkg::req_type item,
   input  i2cm_pkg::cfg_type cfg,
   output i2cm_pkg::rsp_type result
);
   import i2cm_pkg::*;

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam logic [2:0] MAX_FRAME_LEN = 3'(FRAME_BYTES);

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] hold_ff, hold_in;
   logic [7:0]             poll_ff, poll_in;
   logic [3:0]             bit_ff, bit_in;
   logic [7:0]             shift_ff, shift_in;
   logic [7:0]             store_ff [FRAME_BYTES];
   logic [7:0]             store_in [FRAME_BYTES];
   logic [IDX_W-1:0]       index_ff, index_in;
   logic [2:0]             count_ff, count_in;
   logic                   ack_ff, ack_in;
   pins_type               pins_ff, pins_in;
   logic [7:0]             read_ff, read_in;
   logic                   framing_ff, framing_in;

   logic [7:0]             in_bytes [4];
   logic [31:0]            hold_raw, settle_raw;
   logic [COUNT_WIDTH-1:0] hold_dur, settle_dur, dur;
   logic                   busy, fin, eop, ack_ev, ack_val, load_ev, go_ev;
   phase_type              go_ph;
   logic [IDX_W-1:0]       load_idx;
   logic [2:0]             nxt_idx;
   logic [2:0]             flen;

   assign in_bytes[0] = item.byte0;
   assign in_bytes[1] = item.byte1;
   assign in_bytes[2] = item.byte2;
   assign in_bytes[3] = item.byte3;

   // durations wrap at the counter width, zero acts as one tick
   assign hold_raw   = {16'b0, cfg.hold_ticks};
   assign settle_raw = {16'b0, cfg.ack_settle_ticks};
   always_comb begin
      hold_dur   = hold_raw[COUNT_WIDTH-1:0];
      settle_dur = settle_raw[COUNT_WIDTH-1:0];
      if (hold_dur == '0) hold_dur = COUNT_WIDTH'(1);
      if (settle_dur == '0) settle_dur = COUNT_WIDTH'(1);
   end

   always_comb begin
      phase_in   = phase_ff;
      hold_in    = hold_ff;
      poll_in    = poll_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      store_in   = store_ff;
      index_in   = index_ff;
      count_in   = count_ff;
      ack_in     = ack_ff;
      pins_in    = pins_ff;
      read_in    = read_ff;
      framing_in = framing_ff;
      busy       = 1'b0;
      fin        = 1'b0;
      eop        = 1'b0;
      ack_ev     = 1'b0;
      ack_val    = 1'b0;
      load_ev    = 1'b0;
      go_ev      = 1'b0;
      go_ph      = PH_IDLE;
      load_idx   = '0;
      nxt_idx    = '0;
      dur        = hold_dur;
      flen       = item.frame_len;

      // accept a command while idle
      if (phase_ff == PH_IDLE && item.cmd_valid) begin
         framing_in = 1'b0;
         hold_in    = '0;
         case (mode_type'(item.mode))
            MODE_START: begin
               phase_in = PH_ST_A;
            end
            MODE_STOP: begin
               phase_in = PH_SP_A;
            end
            MODE_WRITE: begin
               shift_in = item.byte0;
               bit_in   = '0;
               phase_in = PH_WR_D;
            end
            MODE_CHECK_ACK: begin
               phase_in = PH_CK_R;
            end
            MODE_READ: begin
               shift_in = '0;
               bit_in   = '0;
               phase_in = PH_RD_L;
            end
            MODE_MASTER_ACK: begin
               shift_in = ACK_PATTERN;
               phase_in = PH_MA_D;
            end
            MODE_MASTER_NAK: begin
               shift_in = NACK_PATTERN;
               phase_in = PH_MA_D;
            end
            MODE_FRAME: begin
               for (int i = 0; i < FRAME_BYTES; i++) store_in[i] = in_bytes[i];
               if (flen < MIN_FRAME_LEN) flen = MIN_FRAME_LEN;
               if (flen > MAX_FRAME_LEN) flen = MAX_FRAME_LEN;
               count_in   = flen;
               index_in   = '0;
               ack_in     = 1'b1;
               framing_in = 1'b1;
               phase_in   = PH_ST_A;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (phase_in != PH_IDLE) begin
         busy = 1'b1;
         // pin action on the first tick of a phase
         if (hold_in == '0) begin
            case (phase_in)
               PH_ST_A: pins_in = '{scl: 1'b1, sda: 1'b1, oe: 1'b1};
               PH_ST_B: pins_in.sda = 1'b0;
               PH_ST_C: pins_in.scl = 1'b0;
               PH_SP_A: pins_in = '{scl: 1'b0, sda: 1'b0, oe: 1'b1};
               PH_SP_B: pins_in.scl = 1'b1;
               PH_SP_C: pins_in.sda = 1'b1;
               PH_WR_D: pins_in.sda = shift_in[7];
               PH_WR_H: pins_in.scl = 1'b1;
               PH_WR_L: pins_in.scl = 1'b0;
               PH_CK_R: pins_in.oe = 1'b0;
               PH_CK_S: pins_in.scl = 1'b1;
               PH_RD_L: begin
                  pins_in.oe  = 1'b0;
                  pins_in.scl = 1'b0;
               end
               PH_RD_H: pins_in.scl = 1'b1;
               PH_RD_S: shift_in = {shift_in[6:0], item.sda_in};
               PH_RD_E: begin
                  pins_in.scl = 1'b0;
                  pins_in.oe  = 1'b1;
               end
               PH_MA_D: begin
                  pins_in.oe  = 1'b1;
                  pins_in.sda = shift_in[7];
               end
               PH_MA_H: pins_in.scl = 1'b1;
               PH_MA_E: pins_in.scl = 1'b0;
               default: pins_in = pins_in;
            endcase
         end

         case (phase_in)
            PH_CK_P: begin
               if (hold_in == '0) begin
                  poll_in = cfg.poll_limit;
                  if (!item.sda_in) begin
                     ack_ev  = 1'b1;
                     ack_val = 1'b1;
                  end else begin
                     hold_in = COUNT_WIDTH'(1);
                  end
               end else begin
                  poll_in = poll_in - 8'd1;
                  // running out of polls fails even on a low sample
                  if (poll_in == '0) begin
                     ack_ev  = 1'b1;
                     ack_val = 1'b0;
                  end else if (!item.sda_in) begin
                     ack_ev  = 1'b1;
                     ack_val = 1'b1;
                  end
               end
            end
            PH_RD_E: begin
               read_in = shift_in;
               fin     = 1'b1;
            end
            PH_MA_E: begin
               fin = 1'b1;
            end
            default: begin
               dur     = (phase_in == PH_CK_S) ? settle_dur : hold_dur;
               hold_in = hold_in + COUNT_WIDTH'(1);
               if (!(hold_in != '0 && hold_in < dur)) eop = 1'b1;
            end
         endcase

         if (eop) begin
            go_ev = 1'b1;
            case (phase_in)
               PH_ST_A: go_ph = PH_ST_B;
               PH_ST_B: go_ph = PH_ST_C;
               PH_ST_C: begin
                  if (!framing_in) begin
                     fin = 1'b1;
                  end else begin
                     index_in = '0;
                     load_ev  = 1'b1;
                     load_idx = '0;
                  end
               end
               PH_SP_A: go_ph = PH_SP_B;
               PH_SP_B: go_ph = PH_SP_C;
               PH_SP_C: fin = 1'b1;
               PH_WR_D: go_ph = PH_WR_H;
               PH_WR_H: go_ph = PH_WR_L;
               PH_WR_L: begin
                  shift_in = {shift_in[6:0], 1'b0};
                  bit_in   = bit_in + 4'd1;
                  if (bit_in >= BITS_PER_BYTE) begin
                     if (!framing_in) fin = 1'b1;
                     else go_ph = PH_CK_R;
                  end else begin
                     go_ph = PH_WR_D;
                  end
               end
               PH_CK_R: go_ph = PH_CK_S;
               PH_CK_S: go_ph = PH_CK_P;
               PH_RD_L: go_ph = PH_RD_H;
               PH_RD_H: go_ph = PH_RD_S;
               PH_RD_S: begin
                  bit_in = bit_in + 4'd1;
                  go_ph  = (bit_in >= BITS_PER_BYTE) ? PH_RD_E : PH_RD_L;
               end
               PH_MA_D: go_ph = PH_MA_H;
               PH_MA_H: go_ph = PH_MA_E;
               default: fin = 1'b1;
            endcase
         end

         if (ack_ev) begin
            pins_in.oe  = 1'b1;
            pins_in.scl = 1'b0;
            if (!framing_in) begin
               ack_in = ack_val;
               fin    = 1'b1;
            end else begin
               if (!ack_val) ack_in = 1'b0;
               // a missed ack does not stop the frame
               nxt_idx = 3'(index_in) + 3'd1;
               if (nxt_idx >= count_in || nxt_idx >= MAX_FRAME_LEN) begin
                  go_ev = 1'b1;
                  go_ph = PH_SP_A;
               end else begin
                  index_in = nxt_idx[IDX_W-1:0];
                  load_ev  = 1'b1;
                  load_idx = nxt_idx[IDX_W-1:0];
               end
            end
         end

         if (load_ev) begin
            shift_in = store_in[load_idx];
            bit_in   = '0;
            go_ev    = 1'b1;
            go_ph    = PH_WR_D;
         end

         if (go_ev) begin
            phase_in = go_ph;
            hold_in  = '0;
         end

         if (fin) begin
            phase_in   = PH_IDLE;
            hold_in    = '0;
            framing_in = 1'b0;
         end
      end
   end

   assign result = '{scl_out:   pins_in.scl,
                     sda_out:   pins_in.sda,
                     sda_oe:    pins_in.oe,
                     busy_res:  busy,
                     done_res:  fin,
                     ack_ok:    ack_in,
                     read_data: read_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         hold_ff    <= '0;
         poll_ff    <= '0;
         bit_ff     <= '0;
         shift_ff   <= '0;
         index_ff   <= '0;
         count_ff   <= MIN_FRAME_LEN;
         ack_ff     <= 1'b1;
         pins_ff    <= '{scl: 1'b1, sda: 1'b1, oe: 1'b1};
         read_ff    <= '0;
         framing_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         hold_ff    <= hold_in;
         poll_ff    <= poll_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         index_ff   <= index_in;
         count_ff   <= count_in;
         ack_ff     <= ack_in;
         pins_ff    <= pins_in;
         read_ff    <= read_in;
         framing_ff <= framing_in;
      end
   end

   // frame bytes hold no reset value
   always_ff @(posedge clock) begin
      if (step) store_ff <= store_in;
   end

endmodule
